// ===== hw/rtl/domino_tiling_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Domino tiling counter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef DOMINO_TILING_COUNTER_DEFINES_SVH
`define DOMINO_TILING_COUNTER_DEFINES_SVH

// Condition holds at every clock edge.
`define DTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define DTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Domino tiling counter package
// Sizes, command and status bundles, and the row profile compatibility test.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int MAX_COLS  = 11;
  localparam int MAX_ROWS  = 11;
  localparam int MASK_W    = MAX_COLS;
  localparam int SIZE_W    = 4;
  localparam int COUNT_W   = 63;
  localparam int ADDR_W    = MASK_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic load;
    logic seed;
    logic scan;
    logic next_row;
    logic ans_rd;
    logic ans_cap;
  } cmd_t;

  typedef struct packed {
    logic size_ok;
    logic cur_last;
    logic prev_last;
    logic row_done;
  } status_t;

  // Every column covered, and each run of vertical-over-vertical bits pairs up.
  function automatic logic fits(input logic [MASK_W-1:0] cur,
                                input logic [MASK_W-1:0] prev,
                                input logic [MASK_W-1:0] full);
    logic [MASK_W-1:0] both;
    logic [MASK_W:0]   both_x;
    logic              pstart;
    logic              st;
    logic              ok;
    both   = cur & prev & full;
    both_x = {1'b0, both};
    pstart = 1'b0;
    ok     = (((cur | prev) & full) == full);
    for (int i = 0; i < MASK_W; i++) begin
      st = both_x[i] & ~pstart;
      if (st && !both_x[i+1]) begin
        ok = 1'b0;
      end
      pstart = st;
    end
    return ok;
  endfunction

endpackage

// ===== hw/rtl/dtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Domino tiling counter controller
// Sequences seeding, row scans, answer read and result handoff.
// ----------------------------------------------------------------------------
`include "domino_tiling_counter_defines.svh"

module dtc_ctrl
  import dtc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_ANSRD = 3'd6;
  localparam logic [2:0] S_CAP   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_busy    = out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        state_d = status_i.size_ok ? S_SEED : S_CAP;
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        if (status_i.cur_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = status_i.row_done ? S_ANSRD : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.cur_last && status_i.prev_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.next_row = 1'b1;
        state_d        = S_CHECK;
      end
      S_ANSRD: begin
        cmd_o.ans_rd = 1'b1;
        state_d      = S_CAP;
      end
      S_CAP: begin
        if (!out_busy) begin
          cmd_o.ans_cap = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ans_cap) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DTC_ASSERT_ALWAYS(a_cmd_onehot,
    $onehot0({cmd_o.load, cmd_o.seed, cmd_o.scan, cmd_o.next_row, cmd_o.ans_rd, cmd_o.ans_cap}),
    "controller issued overlapping commands")
  `DTC_ASSERT_ALWAYS(a_work_needs_size, !(cmd_o.seed || cmd_o.scan) || status_i.size_ok,
    "profile work started on an invalid board size")
  `DTC_ASSERT_NEXT(a_cap_shows_result, cmd_o.ans_cap, out_valid_o,
    "captured result not presented")

endmodule

// ===== hw/rtl/dtc_datapath.sv =====
// ----------------------------------------------------------------------------
// Domino tiling counter datapath
// Mask counters, ping-pong profile memory and the saturating accumulator.
// ----------------------------------------------------------------------------
`include "domino_tiling_counter_defines.svh"

module dtc_datapath
  import dtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SIZE_W-1:0]  rows_i,
  input  logic [SIZE_W-1:0]  cols_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic [COUNT_W-1:0] tiling_count_o
);

  logic [SIZE_W-1:0]  rows_q, cols_q;
  logic [MASK_W-1:0]  full_q, full_d;
  logic [MASK_W-1:0]  cur_q, cur_d;
  logic [MASK_W-1:0]  prev_q, prev_d;
  logic [SIZE_W-1:0]  row_q, row_d;
  logic               src_q, src_d;
  logic               s1_valid_q;
  logic               s1_fit_q;
  logic               s1_last_q;
  logic [MASK_W-1:0]  s1_cur_q;
  logic [COUNT_W-1:0] acc_q, acc_d;
  logic [COUNT_W-1:0] rd_q;
  logic [COUNT_W-1:0] result_q;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] mem_q [MEM_DEPTH];
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [COUNT_W-1:0] wdata;
  logic               cur_last, prev_last;

  assign cur_last  = (cur_q == full_q);
  assign prev_last = (prev_q == full_q);

  assign status_o.size_ok   = (rows_q != '0) && (rows_q <= SIZE_W'(MAX_ROWS)) &&
                              (cols_q != '0) && (cols_q <= SIZE_W'(MAX_COLS)) &&
                              !(rows_q[0] && cols_q[0]);
  assign status_o.cur_last  = cur_last;
  assign status_o.prev_last = prev_last;
  assign status_o.row_done  = (row_q == rows_q);

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      full_d[i] = (cols_i > SIZE_W'(i));
    end
  end

  always_comb begin
    cur_d  = cur_q;
    prev_d = prev_q;
    row_d  = row_q;
    src_d  = src_q;
    if (cmd_i.load) begin
      cur_d  = '0;
      prev_d = '0;
      row_d  = SIZE_W'(1);
      src_d  = 1'b0;
    end else if (cmd_i.seed) begin
      cur_d = cur_last ? '0 : cur_q + MASK_W'(1);
    end else if (cmd_i.scan) begin
      prev_d = prev_last ? '0 : prev_q + MASK_W'(1);
      if (prev_last) begin
        cur_d = cur_last ? '0 : cur_q + MASK_W'(1);
      end
    end else if (cmd_i.next_row) begin
      row_d = row_q + SIZE_W'(1);
      src_d = ~src_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      prev_q     <= '0;
      row_q      <= '0;
      src_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      row_q      <= row_d;
      src_q      <= src_d;
      s1_valid_q <= cmd_i.scan;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rows_q <= rows_i;
      cols_q <= cols_i;
      full_q <= full_d;
    end
    s1_fit_q  <= fits(cur_q, prev_q, full_q);
    s1_last_q <= prev_last;
    s1_cur_q  <= cur_q;
    if (cmd_i.ans_cap) begin
      result_q <= status_o.size_ok ? rd_q : '0;
    end
  end

  assign sum = {1'b0, acc_q} + {1'b0, rd_q};

  always_comb begin
    acc_d = acc_q;
    if (s1_valid_q) begin
      if (s1_fit_q) begin
        acc_d = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      end
      if (s1_last_q) begin
        acc_d = '0;
      end
    end
  end

  always_comb begin
    if (cmd_i.seed) begin
      mem_we = 1'b1;
      waddr  = {1'b0, cur_q};
      wdata  = COUNT_W'(fits(cur_q, full_q, full_q));
    end else begin
      mem_we = s1_valid_q && s1_last_q;
      waddr  = {~src_q, s1_cur_q};
      wdata  = (s1_fit_q && sum[COUNT_W]) ? COUNT_MAX :
               (s1_fit_q ? sum[COUNT_W-1:0] : acc_q);
    end
  end

  assign mem_re = cmd_i.scan || cmd_i.ans_rd;
  assign raddr  = cmd_i.ans_rd ? {src_q, full_q} : {src_q, prev_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign tiling_count_o = result_q;

  `DTC_ASSERT_ALWAYS(a_no_seed_in_scan, !(cmd_i.seed && s1_valid_q),
    "seed write collides with a row accumulate")
  `DTC_ASSERT_NEXT(a_row_after_drain, cmd_i.scan && cur_last && prev_last,
    !s1_valid_q || s1_last_q, "row scan ended off the last previous mask")

endmodule

// ===== hw/rtl/domino_tiling_counter.sv =====
// ----------------------------------------------------------------------------
// Domino tiling counter
// Counts 1x2 domino tilings of a rows x cols board with a row-profile DP.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with rows_i, cols_i (1..11 each).
// Output channel: out_valid_o / out_stall_i with tiling_count_o.
// A beat moves when valid is high and stall is low. One result beat per
// input beat, in order. The block works on one board at a time; in_stall_o
// is high from the accepted beat until its result is loaded into the output
// register. An odd area or out-of-range size skips the profile work and
// answers 0. Otherwise the run time is set by the single read port of the
// profile memory: one previous-profile entry is read per cycle, for every
// current/previous mask pair of each row. The largest legal board is 10 x 11,
// since 11 x 11 has an odd area. The result register holds while out_stall_i
// is high; a new board is taken even while the last result still waits, and
// its result waits in turn. Reset clears the controller and counters; the
// profile memory needs no clearing since each board rewrites every entry it
// reads.
// ----------------------------------------------------------------------------
module domino_tiling_counter
  import dtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SIZE_W-1:0]  rows_i,
  input  logic [SIZE_W-1:0]  cols_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] tiling_count_o
);

  cmd_t    cmd;
  status_t status;

  dtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rows_i        (rows_i),
    .cols_i        (cols_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .tiling_count_o(tiling_count_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Domino tiling counter testbench
// Sends board sizes, directed then random, and compares each tiling count
// against a row-profile DP computed here. Both channels idle and stall at
// random; two pauses let every pending count drain first.
// ----------------------------------------------------------------------------
module tb;
  import dtc_pkg::*;

  localparam int  NUM_MASKS   = 1 << MAX_COLS;
  localparam int  RANDOM_BDS  = 75;
  localparam int  TAIL_CYCLES = 40;
  localparam longint unsigned COUNT_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    int                gap;
    bit                drain;
  } board_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [SIZE_W-1:0]  rows_i       = '0;
  logic [SIZE_W-1:0]  cols_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [COUNT_W-1:0] tiling_count_o;

  board_t             pending_boards[$];
  logic [COUNT_W-1:0] expected_counts[$];

  int     boards_total   = 0;
  int     boards_sent    = 0;
  int     counts_checked = 0;
  int     counts_nonzero = 0;
  int     errors         = 0;

  board_t staged_board;
  bit     staged         = 1'b0;
  int     gap_left       = 0;
  bit     fire;
  bit     go;

  int     stall_left     = 0;
  int     calm_left      = 0;

  domino_tiling_counter DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rows_i,
    .cols_i,
    .out_valid_o,
    .out_stall_i,
    .tiling_count_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit profile_fits(logic [MASK_W-1:0] cur, logic [MASK_W-1:0] prev,
                                      int ncols);
    int left;
    left = ncols;
    while (left > 0) begin
      left--;
      if (cur[0]) begin
        if (prev[0]) begin
          if (cur[1] && prev[1]) begin
            left--;
            cur  = cur >> 1;
            prev = prev >> 1;
          end else begin
            return 1'b0;
          end
        end
      end else if (!prev[0]) begin
        return 1'b0;
      end
      cur  = cur >> 1;
      prev = prev >> 1;
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    if (a > COUNT_CAP || b > COUNT_CAP - a) begin
      return COUNT_CAP;
    end
    return a + b;
  endfunction

  function automatic logic [COUNT_W-1:0] count_tilings(logic [SIZE_W-1:0] rows,
                                                       logic [SIZE_W-1:0] cols);
    longint unsigned prior_counts[NUM_MASKS];
    longint unsigned new_counts[NUM_MASKS];
    longint unsigned acc;
    int              width;
    int              full;
    int              nrows;
    int              ncols;
    nrows = rows;
    ncols = cols;
    if (nrows < 1 || nrows > MAX_ROWS || ncols < 1 || ncols > MAX_COLS ||
        ((nrows * ncols) % 2) != 0) begin
      return '0;
    end
    width = 1 << ncols;
    full  = width - 1;
    for (int m = 0; m < width; m++) begin
      prior_counts[m] = profile_fits(MASK_W'(m), MASK_W'(full), ncols) ? 64'd1 : 64'd0;
    end
    for (int r = 1; r < nrows; r++) begin
      for (int c = 0; c < width; c++) begin
        acc = 0;
        for (int p = 0; p < width; p++) begin
          if (prior_counts[p] != 0 && profile_fits(MASK_W'(c), MASK_W'(p), ncols)) begin
            acc = sat_sum(acc, prior_counts[p]);
          end
        end
        new_counts[c] = acc;
      end
      for (int c = 0; c < width; c++) begin
        prior_counts[c] = new_counts[c];
      end
    end
    return prior_counts[full][COUNT_W-1:0];
  endfunction

  task automatic add_board(int rows, int cols, int gap, bit drain);
    board_t b;
    b.rows  = SIZE_W'(rows);
    b.cols  = SIZE_W'(cols);
    b.gap   = gap;
    b.drain = drain;
    pending_boards.push_back(b);
    boards_total++;
  endtask

  function automatic int bad_size();
    return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(12, 15);
  endfunction

  // Sender: hold a stalled beat, otherwise count down the gap and present the next board.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rows_i     <= '0;
      cols_i     <= '0;
      staged     = 1'b0;
      gap_left   = 0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        expected_counts.push_back(count_tilings(rows_i, cols_i));
        boards_sent++;
      end
      if (!in_valid_i || fire) begin
        if (!staged && pending_boards.size() > 0) begin
          staged_board = pending_boards.pop_front();
          staged       = 1'b1;
          gap_left     = staged_board.gap;
        end
        go = staged && gap_left == 0 &&
             (!staged_board.drain || expected_counts.size() == 0);
        if (staged && gap_left > 0) begin
          gap_left--;
        end
        if (go) begin
          in_valid_i <= 1'b1;
          rows_i     <= staged_board.rows;
          cols_i     <= staged_board.cols;
          staged     = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each count beat, then draw the stall for the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      calm_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          $error("tiling_count: no count expected, got %0d", tiling_count_o);
          errors++;
        end else begin
          if (tiling_count_o !== expected_counts[0]) begin
            $error("tiling_count: expected %0d, got %0d", expected_counts[0],
                   tiling_count_o);
            errors++;
          end
          void'(expected_counts.pop_front());
        end
        counts_checked++;
        if (tiling_count_o != 0) begin
          counts_nonzero++;
        end
        if (calm_left > 0) begin
          calm_left--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 12);
          if ($urandom_range(0, 9) == 0) begin
            calm_left = 8;
          end
        end
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin
    int sel;
    int rows;
    int cols;
    int gap;

    // Directed boards: known counts, extremes, odd areas and bad sizes.
    add_board(1, 1, $urandom_range(0, 12), 1'b0);
    add_board(2, 1, $urandom_range(0, 12), 1'b0);
    add_board(1, 2, $urandom_range(0, 12), 1'b0);
    add_board(2, 2, $urandom_range(0, 12), 1'b0);
    add_board(3, 2, $urandom_range(0, 12), 1'b0);
    add_board(2, 3, $urandom_range(0, 12), 1'b0);
    add_board(4, 4, $urandom_range(0, 12), 1'b0);
    add_board(11, 2, $urandom_range(0, 12), 1'b0);
    add_board(2, 8, $urandom_range(0, 12), 1'b0);
    add_board(1, 10, $urandom_range(0, 12), 1'b0);
    add_board(1, 11, 0, 1'b0);
    add_board(11, 11, 0, 1'b0);
    add_board(0, 4, 0, 1'b0);
    add_board(4, 0, 0, 1'b0);
    add_board(15, 15, 0, 1'b0);
    add_board(12, 2, 0, 1'b0);
    add_board(2, 12, 0, 1'b0);
    add_board(3, 3, 0, 1'b0);
    add_board(6, 6, 0, 1'b0);
    add_board(10, 1, 0, 1'b0);
    add_board(5, 4, 0, 1'b0);
    add_board(11, 4, 0, 1'b0);
    add_board(8, 5, 0, 1'b0);
    add_board(4, 7, 0, 1'b0);
    add_board(7, 3, 0, 1'b0);

    // Random boards: mostly small legal sizes, some wide ones, odd areas and bad sizes.
    for (int i = 0; i < RANDOM_BDS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        if ($urandom_range(0, 1) == 0) begin
          rows = bad_size();
          cols = $urandom_range(0, 15);
        end else begin
          rows = $urandom_range(0, 15);
          cols = bad_size();
        end
      end else if (sel < 20) begin
        rows = 2 * $urandom_range(0, 5) + 1;
        cols = 2 * $urandom_range(0, 5) + 1;
      end else if (sel < 30) begin
        rows = $urandom_range(1, 4);
        cols = $urandom_range(6, 7);
      end else if (sel < 33) begin
        rows = $urandom_range(1, 2);
        cols = 8;
      end else begin
        rows = $urandom_range(1, MAX_ROWS);
        cols = $urandom_range(1, 5);
      end
      gap = (i >= 30 && i < 50) ? 0 : $urandom_range(0, 12);
      add_board(rows, cols, gap, i == 0 || i == 60);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (boards_sent < boards_total || expected_counts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d boards sent, %0d counts checked (%0d nonzero), %0d errors",
             boards_sent, counts_checked, counts_nonzero, errors);
    $display("tb: sizes covered legal, odd-area and out-of-range boards up to 11 wide");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #480_000_000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
